// ===== hdl/polyline_equal_arc_marker_defines.svh =====
// Assertion macros used by the checker file of the marker block.
`ifndef POLYLINE_EQUAL_ARC_MARKER_DEFINES_SVH
`define POLYLINE_EQUAL_ARC_MARKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PEM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pem_pkg.sv =====
package pem_pkg;

   localparam int COORD_BITS   = 32;
   localparam int LEN_W        = 48;
   localparam int FB           = 61 - COORD_BITS;
   localparam int SEG_W        = COORD_BITS + 1;
   localparam int TPAR_W       = FB + 1;
   localparam int MUL_B_W      = (COORD_BITS > TPAR_W) ? COORD_BITS : TPAR_W;
   localparam int PROD_W       = COORD_BITS + MUL_B_W;
   localparam int SQ_W         = 2 * COORD_BITS + 1;
   localparam int NUM_W        = (2 * COORD_BITS + 2 > 62) ? 2 * COORD_BITS + 2 : 62;
   localparam int REM_W        = COORD_BITS + 4;
   localparam int STEP_W       = $clog2(NUM_W + 1);
   localparam int CW           = COORD_BITS + 4;
   localparam int ANGLE_W      = 16;
   localparam int INDEX_W      = 6;
   localparam int SEGCNT_W     = 7;
   localparam int SPACING_W    = 32;
   localparam int CORDIC_STEPS = 15;
   localparam int CSTEP_W      = 4;
   localparam int POS_W        = LEN_W + 1;
   localparam int LI_W         = LEN_W + 7;
   localparam int SUM_W        = ((LEN_W > SEG_W) ? LEN_W : SEG_W) + 1;
   localparam int CMP_W        = ((SUM_W > POS_W) ? SUM_W : POS_W) + 1;

   localparam logic MODE_DIVIDE  = 1'b0;
   localparam logic MODE_MEASURE = 1'b1;
   localparam logic [ANGLE_W-1:0] ANGLE_PI = 16'h8000;

   typedef enum logic [1:0] {
      CSR_MODE,
      CSR_SEGMENTS,
      CSR_SPACING,
      CSR_CLOSED
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic                         final_vertex;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] mark_x;
      logic signed [COORD_BITS-1:0] mark_y;
      logic signed [ANGLE_W-1:0]    tangent_angle;
      logic [INDEX_W-1:0]           mark_index;
      logic                         run_end;
      logic                         truncated;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_VTX,
      ST_SQX,
      ST_SQY,
      ST_SQS,
      ST_ROOT,
      ST_ACCUM,
      ST_DECIDE,
      ST_POS,
      ST_POSDIV,
      ST_WAIT0,
      ST_LOAD0,
      ST_WAIT1,
      ST_LOAD1,
      ST_FIND,
      ST_TDIV,
      ST_MULX,
      ST_MULY,
      ST_OFFY,
      ST_CORDIC,
      ST_EMIT
   } state_type;

   // Rounded atan(2^-i) in binary angle units, pi = 32768.
   function automatic logic [ANGLE_W-1:0] atan_entry(input logic [CSTEP_W-1:0] idx);
      logic [ANGLE_W-1:0] val;
      unique case (idx)
         4'd0:    val = 16'd8192;
         4'd1:    val = 16'd4836;
         4'd2:    val = 16'd2555;
         4'd3:    val = 16'd1297;
         4'd4:    val = 16'd651;
         4'd5:    val = 16'd326;
         4'd6:    val = 16'd163;
         4'd7:    val = 16'd81;
         4'd8:    val = 16'd41;
         4'd9:    val = 16'd20;
         4'd10:   val = 16'd10;
         4'd11:   val = 16'd5;
         4'd12:   val = 16'd3;
         4'd13:   val = 16'd1;
         4'd14:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/polyline_equal_arc_marker.sv =====
// Equal-arc marker for a sampled path. Vertices (signed Q16.16) are accepted one per
// start beat while busy is low; each one is stored while the memory has room and the
// length of its segment is added to a running total. The square root of the segment
// length is formed in 33 steps of the shared shift-subtract unit. The vertex flagged
// final_vertex then produces the marks: each mark takes 66 unit steps for its position
// in divide mode, 66 for the fraction along its segment and 15 CORDIC steps for the
// angle, and each segment is loaded and measured again, the first one included, since
// segment lengths are recomputed from the vertex memory.
// Results are strobed on rsp_valid for one cycle each and cannot be held off.
// The vertex memory needs no clearing after reset.
module polyline_equal_arc_marker #(
   parameter int MAX_VERTICES = 512,
   parameter int MAX_MARKS    = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pem_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output pem_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  pem_pkg::csr_index_type            csr_index,
   input  logic [pem_pkg::SPACING_W-1:0]     csr_data
);
   import pem_pkg::*;

   localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int TRW = LEN_W + 1;
   localparam int CB  = COORD_BITS;

   state_type state_ff, state_in;

   logic                   mode_ff, mode_in;
   logic [SEGCNT_W-1:0]    segcnt_ff, segcnt_in;
   logic [SPACING_W-1:0]   spacing_ff, spacing_in;
   logic                   closed_ff, closed_in;
   logic [VCW-1:0]         vcount_ff, vcount_in;
   logic [LEN_W-1:0]       total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [CB-1:0]          vx_ff, vx_in, vy_ff, vy_in;
   logic                   final_ff, final_in;
   logic [CB-1:0]          lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic signed [CB:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic                   walk_ff, walk_in;
   logic [PROD_W-1:0]      mul_ff, mul_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [NUM_W-1:0]       num_ff, num_in, q_ff, q_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SEG_W-1:0]       dvs_ff, dvs_in;
   logic                   root_mode_ff, root_mode_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [SEG_W-1:0]       seglen_ff, seglen_in;
   logic [LEN_W-1:0]       acc_ff, acc_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [LI_W-1:0]        li_ff, li_in;
   logic [SEGCNT_W-1:0]    segs_ff, segs_in, idx_ff, idx_in;
   logic [INDEX_W-1:0]     k_ff, k_in;
   logic                   trunc_ff, trunc_in;
   logic [VAW-1:0]         seg_idx_ff, seg_idx_in;
   logic [CB-1:0]          sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [TPAR_W-1:0]      t_ff, t_in;
   logic [CB-1:0]          px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [ANGLE_W-1:0]     z_ff, z_in;
   logic [CSTEP_W-1:0]     cstep_ff, cstep_in;

   logic [2*CB-1:0]        vmem [MAX_VERTICES];
   logic [2*CB-1:0]        rdata_ff;
   logic                   mem_we;

   // Shared shift-subtract unit and other combinational terms.
   logic [REM_W-1:0]       cand, trial, unit_rem;
   logic [REM_W:0]         diff;
   logic                   ge, unit_done;
   logic [NUM_W-1:0]       unit_q, unit_num;
   logic signed [CB:0]     negx, negy;
   logic [CB-1:0]          magx, magy, mul_a, off;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W:0]        rnd;
   logic [SUM_W-1:0]       sumv, total_sum;
   logic [POS_W-1:0]       next_pos, pos_gap;
   logic                   found, full, run_end, go, degenerate;
   logic [SEGCNT_W-1:0]    segs_clamped;
   logic [TRW-1:0]         trunc_limit;
   logic signed [CW-1:0]   shx, shy;
   logic [CB-1:0]          rd_x, rd_y;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_x = rdata_ff[2*CB-1:CB];
   assign rd_y = rdata_ff[CB-1:0];

   assign negx = -dx_ff;
   assign negy = -dy_ff;
   assign magx = dx_ff[CB] ? negx[CB-1:0] : dx_ff[CB-1:0];
   assign magy = dy_ff[CB] ? negy[CB-1:0] : dy_ff[CB-1:0];

   // One step of restoring division or of the digit-by-digit square root.
   always_comb begin
      if (root_mode_ff) begin
         cand  = {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]};
         trial = {q_ff[REM_W-3:0], 2'b01};
      end else begin
         cand  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
         trial = REM_W'(dvs_ff);
      end
      diff     = {1'b0, cand} - {1'b0, trial};
      ge       = ~diff[REM_W];
      unit_rem = ge ? diff[REM_W-1:0] : cand;
      unit_q   = {q_ff[NUM_W-2:0], ge};
      unit_num = root_mode_ff ? (num_ff << 2) : (num_ff << 1);
   end

   assign unit_done = (step_ff == STEP_W'(1));

   always_comb begin
      unique case (state_ff)
         ST_SQX:  begin mul_a = magx; mul_b = MUL_B_W'(magx); end
         ST_SQY:  begin mul_a = magy; mul_b = MUL_B_W'(magy); end
         ST_MULY: begin mul_a = magy; mul_b = MUL_B_W'(t_ff); end
         default: begin mul_a = magx; mul_b = MUL_B_W'(t_ff); end
      endcase
      mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Offset along the segment, rounded half up in magnitude.
   assign rnd = (PROD_W + 1)'(mul_ff) + ((PROD_W + 1)'(1) << (FB - 1));
   assign off = rnd[FB +: CB];

   assign sumv      = SUM_W'(acc_ff) + SUM_W'(seglen_ff);
   assign found     = (CMP_W'(sumv) >= CMP_W'(pos_ff));
   assign total_sum = SUM_W'(total_ff) + SUM_W'(seglen_ff);
   assign next_pos  = pos_ff + POS_W'(spacing_ff);
   assign pos_gap   = (pos_ff > POS_W'(acc_ff)) ? (pos_ff - POS_W'(acc_ff)) : '0;
   assign full      = (vcount_ff >= VCW'(MAX_VERTICES));
   assign degenerate = (dx_ff == '0) && (dy_ff == '0);
   assign segs_clamped = (segcnt_ff > SEGCNT_W'(MAX_MARKS)) ? SEGCNT_W'(MAX_MARKS)
                                                             : segcnt_ff;
   assign trunc_limit = TRW'(spacing_ff) * TRW'(MAX_MARKS + 1);
   assign shx = cx_ff >>> cstep_ff;
   assign shy = cy_ff >>> cstep_ff;

   always_comb begin
      if (mode_ff == MODE_DIVIDE) begin
         go = (vcount_ff >= VCW'(2)) && (segs_clamped >= SEGCNT_W'(2)) && (total_ff != '0);
         run_end = (idx_ff == segs_ff - SEGCNT_W'(1));
      end else begin
         go = (vcount_ff >= VCW'(2)) && (spacing_ff != '0)
              && (LEN_W'(spacing_ff) <= total_ff);
         run_end = (k_ff == INDEX_W'(MAX_MARKS - 1)) || (next_pos > POS_W'(total_ff));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_VTX;
         ST_VTX: begin
            if (full || vcount_ff == '0) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_SQS;
         ST_SQS:    state_in = ST_ROOT;
         ST_ROOT:   if (unit_done) state_in = walk_ff ? ST_FIND : ST_ACCUM;
         ST_ACCUM:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = (final_ff && go) ? ST_POS : ST_IDLE;
         ST_POS: begin
            if (mode_ff == MODE_DIVIDE) begin
               state_in = ST_POSDIV;
            end else begin
               state_in = (k_ff == '0) ? ST_WAIT0 : ST_FIND;
            end
         end
         ST_POSDIV: if (unit_done) state_in = (k_ff == '0) ? ST_WAIT0 : ST_FIND;
         ST_WAIT0:  state_in = ST_LOAD0;
         ST_LOAD0:  state_in = ST_WAIT1;
         ST_WAIT1:  state_in = ST_LOAD1;
         ST_LOAD1:  state_in = ST_SQX;
         ST_FIND: begin
            if (!found) begin
               state_in = ST_WAIT1;
            end else begin
               state_in = (seglen_ff == '0) ? ST_MULX : ST_TDIV;
            end
         end
         ST_TDIV:   if (unit_done) state_in = ST_MULX;
         ST_MULX:   state_in = ST_MULY;
         ST_MULY:   state_in = ST_OFFY;
         ST_OFFY:   state_in = degenerate ? ST_EMIT : ST_CORDIC;
         ST_CORDIC: if (cstep_ff == CSTEP_W'(CORDIC_STEPS - 1)) state_in = ST_EMIT;
         ST_EMIT:   state_in = run_end ? ST_IDLE : ST_POS;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Configuration writes.
   always_comb begin
      mode_in    = mode_ff;
      segcnt_in  = segcnt_ff;
      spacing_in = spacing_ff;
      closed_in  = closed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:     mode_in    = csr_data[0];
            CSR_SEGMENTS: segcnt_in  = csr_data[SEGCNT_W-1:0];
            CSR_SPACING:  spacing_in = csr_data;
            CSR_CLOSED:   closed_in  = csr_data[0];
         endcase
      end
   end

   // Datapath.
   always_comb begin
      vcount_in    = vcount_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      final_in     = final_ff;
      lastx_in     = lastx_ff;
      lasty_in     = lasty_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      walk_in      = walk_ff;
      sq_in        = sq_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      root_mode_in = root_mode_ff;
      step_in      = step_ff;
      seglen_in    = seglen_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      li_in        = li_ff;
      segs_in      = segs_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      trunc_in     = trunc_ff;
      seg_idx_in   = seg_idx_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      t_in         = t_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      cstep_in     = cstep_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            vx_in    = req_data.vertex_x;
            vy_in    = req_data.vertex_y;
            final_in = req_data.final_vertex;
         end
         ST_VTX: begin
            mem_we  = ~full;
            dx_in   = {vx_ff[CB-1], vx_ff} - {lastx_ff[CB-1], lastx_ff};
            dy_in   = {vy_ff[CB-1], vy_ff} - {lasty_ff[CB-1], lasty_ff};
            walk_in = 1'b0;
            if (!full && vcount_ff == '0) begin
               lastx_in  = vx_ff;
               lasty_in  = vy_ff;
               vcount_in = vcount_ff + VCW'(1);
            end
         end
         ST_SQY: sq_in = SQ_W'(mul_ff);
         ST_SQS: begin
            num_in       = NUM_W'(sq_ff + SQ_W'(mul_ff));
            rem_in       = '0;
            q_in         = '0;
            root_mode_in = 1'b1;
            step_in      = STEP_W'(NUM_W / 2);
         end
         ST_ROOT, ST_POSDIV, ST_TDIV: begin
            rem_in  = unit_rem;
            q_in    = unit_q;
            num_in  = unit_num;
            step_in = step_ff - STEP_W'(1);
            if (unit_done) begin
               unique case (state_ff)
                  ST_ROOT:   seglen_in = unit_q[SEG_W-1:0];
                  ST_POSDIV: pos_in    = unit_q[POS_W-1:0];
                  default:   t_in      = unit_q[TPAR_W-1:0];
               endcase
            end
         end
         ST_ACCUM: begin
            total_in  = (total_sum > SUM_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                            : total_sum[LEN_W-1:0];
            lastx_in  = vx_ff;
            lasty_in  = vy_ff;
            vcount_in = vcount_ff + VCW'(1);
         end
         ST_DECIDE: begin
            segs_in    = segs_clamped;
            idx_in     = closed_ff ? '0 : SEGCNT_W'(1);
            li_in      = closed_ff ? '0 : LI_W'(total_ff);
            pos_in     = POS_W'(spacing_ff);
            trunc_in   = (mode_ff == MODE_MEASURE) && (trunc_limit <= TRW'(total_ff));
            k_in       = '0;
            acc_in     = '0;
            seg_idx_in = '0;
            if (final_ff && !go) begin
               vcount_in = '0;
               total_in  = '0;
            end
         end
         ST_POS: begin
            num_in       = NUM_W'(li_ff);
            dvs_in       = SEG_W'(segs_ff);
            rem_in       = '0;
            q_in         = '0;
            root_mode_in = 1'b0;
            step_in      = STEP_W'(NUM_W);
         end
         ST_LOAD0: begin
            sx_in      = rd_x;
            sy_in      = rd_y;
            seg_idx_in = VAW'(1);
         end
         ST_LOAD1: begin
            ex_in   = rd_x;
            ey_in   = rd_y;
            dx_in   = {rd_x[CB-1], rd_x} - {sx_ff[CB-1], sx_ff};
            dy_in   = {rd_y[CB-1], rd_y} - {sy_ff[CB-1], sy_ff};
            walk_in = 1'b1;
         end
         ST_FIND: begin
            if (!found) begin
               // Marks never move backwards, so the walk resumes where it stopped.
               acc_in     = sumv[LEN_W-1:0];
               seg_idx_in = seg_idx_ff + VAW'(1);
               sx_in      = ex_ff;
               sy_in      = ey_ff;
            end else begin
               t_in         = '0;
               num_in       = NUM_W'(pos_gap) << FB;
               dvs_in       = seglen_ff;
               rem_in       = '0;
               q_in         = '0;
               root_mode_in = 1'b0;
               step_in      = STEP_W'(NUM_W);
            end
         end
         ST_MULY: px_in = dx_ff[CB] ? (sx_ff - off) : (sx_ff + off);
         ST_OFFY: begin
            py_in    = dy_ff[CB] ? (sy_ff - off) : (sy_ff + off);
            cstep_in = '0;
            if (degenerate) begin
               z_in = '0;
            end else if (dx_ff[CB]) begin
               cx_in = -CW'(dx_ff);
               cy_in = -CW'(dy_ff);
               z_in  = ANGLE_PI;
            end else begin
               cx_in = CW'(dx_ff);
               cy_in = CW'(dy_ff);
               z_in  = '0;
            end
         end
         ST_CORDIC: begin
            cstep_in = cstep_ff + CSTEP_W'(1);
            if (!cy_ff[CW-1] && cy_ff != '0) begin
               cx_in = cx_ff + shy;
               cy_in = cy_ff - shx;
               z_in  = z_ff + atan_entry(cstep_ff);
            end else begin
               cx_in = cx_ff - shy;
               cy_in = cy_ff + shx;
               z_in  = z_ff - atan_entry(cstep_ff);
            end
         end
         ST_EMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.mark_x        = px_ff;
            rsp_in.mark_y        = py_ff;
            rsp_in.tangent_angle = z_ff;
            rsp_in.mark_index    = k_ff;
            rsp_in.run_end       = run_end;
            rsp_in.truncated     = trunc_ff;
            k_in                 = k_ff + INDEX_W'(1);
            idx_in               = idx_ff + SEGCNT_W'(1);
            li_in                = li_ff + LI_W'(total_ff);
            pos_in               = next_pos;
            if (run_end) begin
               vcount_in = '0;
               total_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_DIVIDE;
         segcnt_ff    <= SEGCNT_W'(2);
         spacing_ff   <= SPACING_W'(65536);
         closed_ff    <= 1'b0;
         vcount_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         segcnt_ff    <= segcnt_in;
         spacing_ff   <= spacing_in;
         closed_ff    <= closed_in;
         vcount_ff    <= vcount_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      final_ff     <= final_in;
      lastx_ff     <= lastx_in;
      lasty_ff     <= lasty_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      walk_ff      <= walk_in;
      mul_ff       <= mul_in;
      sq_ff        <= sq_in;
      num_ff       <= num_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      root_mode_ff <= root_mode_in;
      step_ff      <= step_in;
      seglen_ff    <= seglen_in;
      acc_ff       <= acc_in;
      pos_ff       <= pos_in;
      li_ff        <= li_in;
      segs_ff      <= segs_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      trunc_ff     <= trunc_in;
      seg_idx_ff   <= seg_idx_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      t_ff         <= t_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      z_ff         <= z_in;
      cstep_ff     <= cstep_in;
   end

   // Vertex memory: one write port for arriving vertices, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[vcount_ff[VAW-1:0]] <= {vx_ff, vy_ff};
      end
      rdata_ff <= vmem[seg_idx_ff];
   end

endmodule

// ===== hdl/pem_checker.sv =====
`include "polyline_equal_arc_marker_defines.svh"

module pem_checker #(
   parameter int MAX_MARKS = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input pem_pkg::rsp_type rsp_data
);
   import pem_pkg::*;

   // An accepted vertex keeps the block occupied for at least the next cycle.
   `PEM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

   // Marks of a run are separated by work on the next mark, never back to back.
   `PEM_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobes back to back")

   // While marks of the run remain, the block must still be working.
   `PEM_ASSERT_NOW(a_more_busy, rsp_valid && !rsp_data.run_end, busy, "run left early")

   // A cut-off run always ends on the last permitted mark.
   `PEM_ASSERT_NOW(a_trunc_full, rsp_valid && rsp_data.truncated && rsp_data.run_end, rsp_data.mark_index == INDEX_W'(MAX_MARKS - 1), "truncated run not full")

endmodule

bind polyline_equal_arc_marker pem_checker #(.MAX_MARKS(MAX_MARKS)) u_pem_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_polyline_equal_arc_marker.sv =====
`timescale 1ns / 100ps

module tb_polyline_equal_arc_marker;
   import pem_pkg::*;

   localparam int MAX_VERTICES = 512;
   localparam int MAX_MARKS    = 64;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int SETTLE       = 400;
   localparam int RANDOM_ITEMS = 64;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_MODE;
   logic [31:0]      csr_data = '0;

   polyline_equal_arc_marker dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's registers and path state.
   logic             mode_sel;
   int unsigned      seg_count;
   longint unsigned  spacing;
   logic             closed;
   longint           path_x [MAX_VERTICES];
   longint           path_y [MAX_VERTICES];
   int unsigned      path_len;
   longint unsigned  arc_total;

   rsp_type          mark_q[$];
   int               errors = 0;
   int               idle_pct = 0;
   int               items_sent = 0;
   longint unsigned  cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Exact integer root of dx^2 + dy^2.
   function automatic longint unsigned segment_length(input longint dx, input longint dy);
      logic [127:0] sq, c;
      logic [127:0] r;
      r = '0;
      sq = 128'(magnitude(dx)) * 128'(magnitude(dx))
           + 128'(magnitude(dy)) * 128'(magnitude(dy));
      for (int b = COORD_BITS + 1; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= sq) r = c;
      end
      return longint'(r[63:0]);
   endfunction

   function automatic logic [15:0] atan_step(input int i);
      int unsigned tab [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                10, 5, 3, 1, 1};
      return tab[i][15:0];
   endfunction

   function automatic logic [15:0] tangent_of(input longint dx, input longint dy);
      longint x, y, xs;
      logic [15:0] z;
      x = dx;
      y = dy;
      z = '0;
      if (dx == 0 && dy == 0) return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = ANGLE_PI;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x;
         if (y > 0) begin
            x += (y >>> i);
            y -= (xs >>> i);
            z += atan_step(i);
         end else begin
            x -= (y >>> i);
            y += (xs >>> i);
            z -= atan_step(i);
         end
      end
      return z;
   endfunction

   function automatic longint lerp_offset(input longint d, input longint unsigned num,
                                          input longint unsigned seg);
      logic [127:0] t, o;
      t = (seg != 0) ? (128'(num) << FB) / 128'(seg) : '0;
      o = (128'(magnitude(d)) * t + (128'd1 << (FB - 1))) >> FB;
      return (d < 0) ? -longint'(o[63:0]) : longint'(o[63:0]);
   endfunction

   function automatic rsp_type mark_at(input longint unsigned s, input int k);
      rsp_type m;
      longint unsigned acc, seg, num;
      longint dx, dy, px, py;
      logic [15:0] ang;
      logic found;
      acc = 0;
      found = 1'b0;
      for (int i = 1; i < path_len && !found; i++) begin
         dx = path_x[i] - path_x[i-1];
         dy = path_y[i] - path_y[i-1];
         seg = segment_length(dx, dy);
         if (acc + seg >= s) begin
            num = (s > acc) ? s - acc : 0;
            ang = tangent_of(dx, dy);
            px = path_x[i-1] + lerp_offset(dx, num, seg);
            py = path_y[i-1] + lerp_offset(dy, num, seg);
            found = 1'b1;
         end
         acc += seg;
      end
      if (!found) begin
         ang = tangent_of(path_x[path_len-1] - path_x[path_len-2],
                          path_y[path_len-1] - path_y[path_len-2]);
         px = path_x[path_len-1];
         py = path_y[path_len-1];
      end
      m.mark_x = px[31:0];
      m.mark_y = py[31:0];
      m.tangent_angle = ang;
      m.mark_index = k[5:0];
      m.run_end = 1'b0;
      m.truncated = 1'b0;
      return m;
   endfunction

   task automatic predict_marks(input req_type v);
      rsp_type run[$];
      longint unsigned s;
      int unsigned segs;
      if (path_len < MAX_VERTICES) begin
         if (path_len > 0) begin
            arc_total += segment_length(longint'(v.vertex_x) - path_x[path_len-1],
                                        longint'(v.vertex_y) - path_y[path_len-1]);
            if (arc_total > 64'hFFFF_FFFF_FFFF) arc_total = 64'hFFFF_FFFF_FFFF;
         end
         path_x[path_len] = longint'(v.vertex_x);
         path_y[path_len] = longint'(v.vertex_y);
         path_len++;
      end
      if (!v.final_vertex) return;
      if (path_len >= 2) begin
         if (mode_sel == MODE_DIVIDE) begin
            segs = (seg_count > MAX_MARKS) ? MAX_MARKS : seg_count;
            if (segs >= 2 && arc_total > 0)
               for (int i = closed ? 0 : 1; i < segs; i++)
                  run = {run, mark_at(arc_total * i / segs, run.size())};
         end else if (spacing > 0) begin
            s = spacing;
            while (s <= arc_total && run.size() < MAX_MARKS) begin
               run = {run, mark_at(s, run.size())};
               s += spacing;
            end
            if (run.size() == MAX_MARKS && s <= arc_total)
               foreach (run[k]) run[k].truncated = 1'b1;
         end
      end
      if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
      mark_q = {mark_q, run};
      path_len = 0;
      arc_total = 0;
   endtask

   // Results cannot be held off, so every strobed beat is checked at the falling edge.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (mark_q.size() == 0) begin
            report($sformatf("unexpected mark %p", rsp_data));
         end else begin
            want = mark_q.pop_front();
            if (rsp_data.mark_x !== want.mark_x)
               report($sformatf("mark_x %h, want %h", rsp_data.mark_x, want.mark_x));
            if (rsp_data.mark_y !== want.mark_y)
               report($sformatf("mark_y %h, want %h", rsp_data.mark_y, want.mark_y));
            if (rsp_data.tangent_angle !== want.tangent_angle)
               report($sformatf("tangent_angle %h, want %h", rsp_data.tangent_angle,
                                want.tangent_angle));
            if (rsp_data.mark_index !== want.mark_index)
               report($sformatf("mark_index %0d, want %0d", rsp_data.mark_index,
                                want.mark_index));
            if (rsp_data.run_end !== want.run_end)
               report($sformatf("run_end %b, want %b", rsp_data.run_end, want.run_end));
            if (rsp_data.truncated !== want.truncated)
               report($sformatf("truncated %b, want %b", rsp_data.truncated,
                                want.truncated));
         end
      end
   end

   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y, input logic fin);
      req_type v;
      logic done;
      v.vertex_x = x;
      v.vertex_y = y;
      v.final_vertex = fin;
      start <= 1'b1;
      req_data <= v;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = !busy;
         @(posedge clock);
      end
      predict_marks(v);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Lets every outstanding mark arrive, then gives the block time to finish a run
   // that produced nothing.
   task automatic drain;
      start <= 1'b0;
      while (mark_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      logic done;
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:     mode_sel = val[0];
         CSR_SEGMENTS: seg_count = val[6:0];
         CSR_SPACING:  spacing = val;
         CSR_CLOSED:   closed = val[0];
      endcase
   endtask

   task automatic test_divide_basics;
      send_vertex(32'h0, 32'h0, 1'b0);
      send_vertex(32'h000A_0000, 32'h0, 1'b1);
      write_reg(CSR_SEGMENTS, 32'd5);
      write_reg(CSR_CLOSED, 32'd1);
      send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      write_reg(CSR_SEGMENTS, 32'd127);
      send_vertex(32'hFFF0_0000, 32'h0003_0000, 1'b0);
      send_vertex(32'h0010_0000, 32'hFFFD_0000, 1'b1);
      write_reg(CSR_SEGMENTS, 32'd64);
      write_reg(CSR_CLOSED, 32'd0);
      send_vertex(32'h0, 32'h0, 1'b0);
      send_vertex(32'h0, 32'h0040_0000, 1'b1);
   endtask

   task automatic test_special_cases;
      write_reg(CSR_SEGMENTS, 32'd1);
      send_vertex(32'h0, 32'h0, 1'b0);
      send_vertex(32'h0001_0000, 32'h0, 1'b1);
      write_reg(CSR_SEGMENTS, 32'd0);
      send_vertex(32'h0, 32'h0, 1'b0);
      send_vertex(32'h0001_0000, 32'h0, 1'b1);
      write_reg(CSR_SEGMENTS, 32'd4);
      write_reg(CSR_CLOSED, 32'd1);
      // A single vertex, a path of no length and a leading repeated vertex.
      send_vertex(32'h1234_5678, 32'h8765_4321, 1'b1);
      send_vertex(32'h0005_0000, 32'h0005_0000, 1'b0);
      send_vertex(32'h0005_0000, 32'h0005_0000, 1'b1);
      send_vertex(32'h0005_0000, 32'h0005_0000, 1'b0);
      send_vertex(32'h0005_0000, 32'h0005_0000, 1'b0);
      send_vertex(32'hFFFB_0000, 32'h0008_0000, 1'b1);
      write_reg(CSR_MODE, 32'(MODE_MEASURE));
      write_reg(CSR_SPACING, 32'd0);
      send_vertex(32'h0, 32'h0, 1'b0);
      send_vertex(32'h0010_0000, 32'h0, 1'b1);
      write_reg(CSR_SPACING, 32'h0000_8000);
      send_vertex(32'h0, 32'h0, 1'b0);
      send_vertex(32'h0040_0000, 32'h0040_0000, 1'b1);
      write_reg(CSR_SPACING, 32'hFFFF_FFFF);
      send_vertex(32'h8000_0000, 32'h0, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h0, 1'b1);
      write_reg(CSR_MODE, 32'(MODE_DIVIDE));
      write_reg(CSR_CLOSED, 32'd0);
   endtask

   // More vertices than the store holds; the surplus is dropped but still ends the path.
   task automatic test_full_store;
      write_reg(CSR_SEGMENTS, 32'd2);
      for (int i = 0; i < MAX_VERTICES + 2; i++)
         send_vertex(32'(i * 32'h0001_0000), 32'((i % 3) * 32'h0000_4000),
                     i == MAX_VERTICES + 1);
   endtask

   task automatic test_random_paths(input int count);
      logic [31:0] xs [16];
      logic [31:0] ys [16];
      int n, style, stop;
      longint unsigned arc;
      logic [31:0] bx, by;
      stop = items_sent + count;
      while (items_sent < stop) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
         style = $urandom_range(3);
         bx = $urandom() >> 2;
         by = $urandom() >> 2;
         if ($urandom_range(1)) bx = -bx;
         if ($urandom_range(1)) by = -by;
         for (int i = 0; i < n; i++) begin
            case (style)
               0: begin
                  xs[i] = $urandom();
                  ys[i] = $urandom();
               end
               1: begin
                  xs[i] = bx + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
                  ys[i] = by + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
               end
               2: begin
                  xs[i] = (i > 0 && $urandom_range(1)) ? xs[i-1]
                                                       : bx + $urandom_range(0, 32'h0010_0000);
                  ys[i] = (i > 0 && $urandom_range(1)) ? ys[i-1]
                                                       : by + $urandom_range(0, 32'h0010_0000);
               end
               default: begin
                  xs[i] = (i % 2) ? bx + $urandom_range(0, 32'h0100_0000) : bx;
                  ys[i] = (i % 2) ? by : by - $urandom_range(0, 32'h0100_0000);
               end
            endcase
            bx = xs[i];
            by = ys[i];
         end
         if ($urandom_range(1)) begin
            write_reg(CSR_MODE, 32'(MODE_DIVIDE));
            write_reg(CSR_SEGMENTS, ($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 12));
            write_reg(CSR_CLOSED, $urandom_range(1));
         end else begin
            arc = 0;
            for (int i = 1; i < n; i++)
               arc += segment_length(longint'($signed(xs[i])) - longint'($signed(xs[i-1])),
                                     longint'($signed(ys[i])) - longint'($signed(ys[i-1])));
            write_reg(CSR_MODE, 32'(MODE_MEASURE));
            if ($urandom_range(9) == 0 || arc == 0)
               write_reg(CSR_SPACING, $urandom_range(1) ? 32'd0 : $urandom());
            else
               write_reg(CSR_SPACING, 32'(arc / $urandom_range(1, 80)) + $urandom_range(1));
         end
         for (int i = 0; i < n; i++)
            send_vertex(xs[i], ys[i], i == n - 1);
      end
   endtask

   initial begin
      mode_sel = MODE_DIVIDE;
      seg_count = 2;
      spacing = 65536;
      closed = 1'b0;
      path_len = 0;
      arc_total = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_divide_basics();
      test_special_cases();
      test_full_store();
      idle_pct = 0;
      test_random_paths(RANDOM_ITEMS / 4);
      idle_pct = 74;
      test_random_paths(RANDOM_ITEMS / 4);
      idle_pct = 0;
      test_random_paths(RANDOM_ITEMS / 4);
      idle_pct = 29;
      test_random_paths(RANDOM_ITEMS / 4);
      drain();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
